/* design/sxs_pkg.sv */
// Shared types, constants and decode helpers for the SIC/XE subset step engine.
`default_nettype none
package sxs_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);

  // item commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // result status
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SKIP  = 3'd2;
  localparam logic [2:0] ST_BREAK = 3'd3;
  localparam logic [2:0] ST_END   = 3'd4;

  // condition code
  localparam logic [1:0] CC_EQ = 2'd0;
  localparam logic [1:0] CC_GT = 2'd1;
  localparam logic [1:0] CC_LT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_LENGTH = 2'd1;
  localparam logic [1:0] CFG_BPADDR = 2'd2;
  localparam logic [1:0] CFG_BPEN   = 2'd3;

  // register codes of format 2
  localparam logic [3:0] RC_A = 4'd0;
  localparam logic [3:0] RC_X = 4'd1;
  localparam logic [3:0] RC_L = 4'd2;
  localparam logic [3:0] RC_B = 4'd3;
  localparam logic [3:0] RC_S = 4'd4;
  localparam logic [3:0] RC_T = 4'd5;

  // opcodes (top six bits, low two cleared)
  localparam logic [7:0] OPC_LDA   = 8'h00;
  localparam logic [7:0] OPC_STA   = 8'h0C;
  localparam logic [7:0] OPC_STX   = 8'h10;
  localparam logic [7:0] OPC_STL   = 8'h14;
  localparam logic [7:0] OPC_COMP  = 8'h28;
  localparam logic [7:0] OPC_JEQ   = 8'h30;
  localparam logic [7:0] OPC_JLT   = 8'h38;
  localparam logic [7:0] OPC_J     = 8'h3C;
  localparam logic [7:0] OPC_JSUB  = 8'h48;
  localparam logic [7:0] OPC_RSUB  = 8'h4C;
  localparam logic [7:0] OPC_LDCH  = 8'h50;
  localparam logic [7:0] OPC_STCH  = 8'h54;
  localparam logic [7:0] OPC_LDB   = 8'h68;
  localparam logic [7:0] OPC_LDT   = 8'h74;
  localparam logic [7:0] OPC_COMPR = 8'hA0;
  localparam logic [7:0] OPC_CLEAR = 8'hB4;
  localparam logic [7:0] OPC_TIXR  = 8'hB8;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, S_DEC0, S_DEC1, S_ADDR, S_IND, S_OPND, S_EXE, S_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] start_address;
    logic [15:0] program_length;
    logic [15:0] breakpoint_address;
    logic        breakpoint_enable;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] pc;
    logic [23:0] a;
    logic [23:0] x;
    logic [23:0] l;
    logic [23:0] b;
    logic [23:0] s;
    logic [23:0] t;
    logic [1:0]  cc;
  } result_t;

  function automatic logic is_fmt2(input logic [7:0] opc);
    return (opc == OPC_CLEAR) || (opc == OPC_COMPR) || (opc == OPC_TIXR);
  endfunction

  function automatic logic is_fmt34(input logic [7:0] opc);
    return (opc == OPC_COMP) || (opc == OPC_J) || (opc == OPC_JEQ) || (opc == OPC_JLT) ||
           (opc == OPC_JSUB) || (opc == OPC_RSUB) || (opc == OPC_LDA) || (opc == OPC_LDB) ||
           (opc == OPC_LDCH) || (opc == OPC_LDT) || (opc == OPC_STA) || (opc == OPC_STL) ||
           (opc == OPC_STX) || (opc == OPC_STCH);
  endfunction

  function automatic logic [1:0] cmp3(input logic [23:0] a, input logic [23:0] b);
    if (a == b) return CC_EQ;
    else if (a > b) return CC_GT;
    else return CC_LT;
  endfunction

endpackage
`default_nettype wire

/* design/sxs_if.sv */
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface sxs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] address;
  logic [7:0]  data;
  modport source (output valid, op, address, data, input ready);
  modport sink   (input valid, op, address, data, output ready);
endinterface

interface sxs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [23:0] pc_out;
  logic [23:0] reg_a_out;
  logic [23:0] reg_x_out;
  logic [23:0] reg_l_out;
  logic [23:0] reg_b_out;
  logic [23:0] reg_s_out;
  logic [23:0] reg_t_out;
  logic [1:0]  cond_code;
  modport source (output valid, status, pc_out, reg_a_out, reg_x_out, reg_l_out,
                  reg_b_out, reg_s_out, reg_t_out, cond_code, input ready);
  modport sink   (input valid, status, pc_out, reg_a_out, reg_x_out, reg_l_out,
                  reg_b_out, reg_s_out, reg_t_out, cond_code, output ready);
endinterface
`default_nettype wire

/* design/sicxe_subset_instruction_step.sv */
// Top level of the SIC/XE subset step engine: configuration, channels, memory.
// Each input beat writes a memory byte, starts the program, or steps one SIC/XE
// instruction, and yields exactly one result beat with status, PC, all six
// registers and the condition code after the item. Items are handled one at a
// time: a byte write, a start or a stop before any fetch goes straight to its
// result; a step reads each memory byte it touches, then decodes and executes.
// A zero or skipped byte is read and decoded alone, a format 2 instruction adds
// its register byte, and a load adds its address and operand bytes, an
// indirect load its indirect address bytes too. Bytes go through the single
// byte-wide memory port with registered read; each byte read has an issue and
// a capture state. A result beat sits in an output register, so the next item
// may be accepted while it waits to be taken. Configuration is to be written
// through cfg_we/cfg_index/cfg_wdata while idle; the block does not enforce it.
`default_nettype none
module sicxe_subset_instruction_step (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sxs_in_if.sink           in_bus,
  sxs_out_if.source        out_bus,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import sxs_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;
  logic              core_rdy, res_valid, res_ready, in_acc;
  result_t           res;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;

  // accept a beat only while the sequencer is idle
  assign in_bus.ready = core_rdy;
  assign in_acc       = in_bus.valid && core_rdy;
  // the output register frees up when empty or when its beat is taken
  assign res_ready    = !out_valid_r || out_bus.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START:  cfg_nxt.start_address = cfg_wdata;
        CFG_LENGTH: cfg_nxt.program_length = cfg_wdata;
        CFG_BPADDR: cfg_nxt.breakpoint_address = cfg_wdata;
        CFG_BPEN:   cfg_nxt.breakpoint_enable = cfg_wdata[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  // load a finished result, hold it until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    if (out_valid_r && out_bus.ready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.status    = out_r.status;
  assign out_bus.pc_out    = out_r.pc;
  assign out_bus.reg_a_out = out_r.a;
  assign out_bus.reg_x_out = out_r.x;
  assign out_bus.reg_l_out = out_r.l;
  assign out_bus.reg_b_out = out_r.b;
  assign out_bus.reg_s_out = out_r.s;
  assign out_bus.reg_t_out = out_r.t;
  assign out_bus.cond_code = out_r.cc;

  sxs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_acc     (in_acc),
    .in_op      (in_bus.op),
    .in_address (in_bus.address),
    .in_data    (in_bus.data),
    .core_rdy   (core_rdy),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata)
  );

  sxs_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );
endmodule
`default_nettype wire

/* design/sxs_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module sxs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule
`default_nettype wire

/* design/sxs_core.sv */
// Sequencer and register file executing one item over many cycles on one memory port.
`default_nettype none
module sxs_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sxs_pkg::cfg_t        cfg,
  input  wire logic                 in_acc,
  input  wire logic [1:0]           in_op,
  input  wire logic [15:0]          in_address,
  input  wire logic [7:0]           in_data,
  output logic                      core_rdy,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output sxs_pkg::result_t          res,
  output logic                      ram_we,
  output logic [sxs_pkg::MEM_AW-1:0] ram_addr,
  output logic [7:0]                ram_wdata,
  input  wire logic [7:0]           ram_rdata
);
  import sxs_pkg::*;

  state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [MEM_AW-1:0] raddr_r, raddr_nxt;
  logic [23:0]       buf_r, buf_nxt;
  logic [7:0]        ir0_r, ir0_nxt;
  logic [23:0]       pc_r, pc_nxt, a_r, a_nxt, x_r, x_nxt, l_r, l_nxt;
  logic [23:0]       b_r, b_nxt, s_r, s_nxt, t_r, t_nxt;
  logic [1:0]        cc_r, cc_nxt;
  logic              halted_r, halted_nxt, atbp_r, atbp_nxt;
  logic [23:0]       ta_r, ta_nxt, ea_r, ea_nxt, wdat_r, wdat_nxt;
  logic              xadd_r, xadd_nxt;
  logic [2:0]        status_r, status_nxt;

  logic [7:0]  opc, b0, b1, b2, b3;
  logic        fn, fi, sic, f4, imm, ind;
  logic [11:0] disp;
  logic [23:0] ta_sum, xi;
  logic [3:0]  r1, r2;
  logic [16:0] prog_end;
  logic        past_end, bp_hit;

  function automatic logic [23:0] reg_val(input logic [3:0] c, input logic [23:0] a,
                                          input logic [23:0] x, input logic [23:0] l,
                                          input logic [23:0] b, input logic [23:0] s,
                                          input logic [23:0] t);
    logic [23:0] v;
    v = '0;
    unique case (c)
      RC_A:    v = a;
      RC_X:    v = x;
      RC_L:    v = l;
      RC_B:    v = b;
      RC_S:    v = s;
      RC_T:    v = t;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign b0   = buf_r[7:0];
  assign opc  = ir0_r & 8'hFC;
  assign fn   = ir0_r[1];
  assign fi   = ir0_r[0];
  assign sic  = !fn && !fi;
  assign imm  = !fn && fi;
  assign ind  = fn && !fi;
  assign b1   = buf_r[23:16];
  assign b2   = buf_r[15:8];
  assign b3   = buf_r[7:0];
  assign f4   = !sic && b1[4];
  assign disp = {b1[3:0], b2};
  assign r1   = buf_r[7:4];
  assign r2   = buf_r[3:0];
  assign xi   = x_r + 24'd1;
  assign ta_sum = ta_r + (xadd_r ? x_r : 24'd0);
  assign prog_end = {1'b0, cfg.start_address} + {1'b0, cfg.program_length};
  assign past_end = pc_r >= {7'd0, prog_end};
  assign bp_hit   = cfg.breakpoint_enable && !atbp_r &&
                    (pc_r == {8'd0, cfg.breakpoint_address});

  assign core_rdy  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res = '{status: status_r, pc: pc_r, a: a_r, x: x_r, l: l_r, b: b_r,
                 s: s_r, t: t_r, cc: cc_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_op == CMD_STEP) && !halted_r && !past_end && !bp_hit) state_nxt = S_RD;
          else state_nxt = S_DONE;
        end
      end
      S_RD:   state_nxt = S_RDW;
      S_RDW:  state_nxt = (cnt_r == 2'd1) ? ret_r : S_RD;
      S_DEC0: begin
        if ((b0 != 8'd0) && (is_fmt2(b0 & 8'hFC) || is_fmt34(b0 & 8'hFC))) state_nxt = S_RD;
        else state_nxt = S_DONE;
      end
      S_DEC1: state_nxt = is_fmt2(opc) ? S_DONE : S_ADDR;
      S_ADDR: state_nxt = ind ? S_RD : S_OPND;
      S_IND:  state_nxt = S_OPND;
      S_OPND: begin
        priority case (1'b1)
          (opc == OPC_COMP) || (opc == OPC_LDA) || (opc == OPC_LDB) ||
          (opc == OPC_LDT) || (opc == OPC_LDCH):
            state_nxt = imm ? S_EXE : S_RD;
          (opc == OPC_STA) || (opc == OPC_STL) || (opc == OPC_STX) || (opc == OPC_STCH):
            state_nxt = S_WR;
          default: state_nxt = S_DONE;
        endcase
      end
      S_EXE:  state_nxt = S_DONE;
      S_WR:   state_nxt = (cnt_r == 2'd1) ? S_DONE : S_WR;
      S_DONE: state_nxt = res_ready ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    ret_nxt = ret_r; cnt_nxt = cnt_r; raddr_nxt = raddr_r; buf_nxt = buf_r;
    ir0_nxt = ir0_r; pc_nxt = pc_r; a_nxt = a_r; x_nxt = x_r; l_nxt = l_r;
    b_nxt = b_r; s_nxt = s_r; t_nxt = t_r; cc_nxt = cc_r; halted_nxt = halted_r;
    atbp_nxt = atbp_r; ta_nxt = ta_r; ea_nxt = ea_r; wdat_nxt = wdat_r;
    xadd_nxt = xadd_r; status_nxt = status_r;
    ram_we = 1'b0; ram_addr = raddr_r; ram_wdata = wdat_r[23:16];
    unique case (state_r)
      S_IDLE: begin
        ram_addr = MEM_AW'(in_address);
        ram_wdata = in_data;
        if (in_acc) begin
          status_nxt = ST_OK;
          unique case (in_op)
            CMD_WRITE: ram_we = 1'b1;
            CMD_START: begin
              a_nxt = '0; x_nxt = '0; l_nxt = '0; b_nxt = '0; s_nxt = '0; t_nxt = '0;
              cc_nxt = CC_EQ; pc_nxt = {8'd0, cfg.start_address};
              atbp_nxt = 1'b0; halted_nxt = 1'b0;
            end
            CMD_STEP: begin
              if (halted_r) status_nxt = ST_END;
              else if (past_end) begin
                halted_nxt = 1'b1; status_nxt = ST_END;
              end else if (bp_hit) begin
                atbp_nxt = 1'b1; status_nxt = ST_BREAK;
              end else begin
                raddr_nxt = pc_r[MEM_AW-1:0]; cnt_nxt = 2'd1; ret_nxt = S_DEC0;
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_RD: ram_addr = raddr_r;
      S_RDW: begin
        buf_nxt = {buf_r[15:0], ram_rdata};
        cnt_nxt = cnt_r - 2'd1;
        raddr_nxt = raddr_r + MEM_AW'(1);
      end
      S_DEC0: begin
        ir0_nxt = b0;
        raddr_nxt = MEM_AW'(pc_r + 24'd1);
        if (b0 == 8'd0) begin
          halted_nxt = 1'b1; status_nxt = ST_END;
        end else if (is_fmt2(b0 & 8'hFC)) begin
          cnt_nxt = 2'd1; ret_nxt = S_DEC1;
        end else if (is_fmt34(b0 & 8'hFC)) begin
          // always fetch three bytes; the third is used by format 4 only
          cnt_nxt = 2'd3; ret_nxt = S_DEC1;
        end else begin
          pc_nxt = pc_r + 24'd1; status_nxt = ST_SKIP;
        end
      end
      S_DEC1: begin
        if (is_fmt2(opc)) begin
          pc_nxt = pc_r + 24'd2;
          status_nxt = ST_EXEC;
          if (opc == OPC_CLEAR) begin
            unique case (r1)
              RC_A: a_nxt = '0;
              RC_X: x_nxt = '0;
              RC_L: l_nxt = '0;
              RC_B: b_nxt = '0;
              RC_S: s_nxt = '0;
              RC_T: t_nxt = '0;
              default: ;
            endcase
          end else if (opc == OPC_COMPR) begin
            cc_nxt = cmp3(reg_val(r1, a_r, x_r, l_r, b_r, s_r, t_r),
                          reg_val(r2, a_r, x_r, l_r, b_r, s_r, t_r));
          end else begin
            x_nxt = xi;
            cc_nxt = cmp3(xi, (r1 == RC_X) ? xi : reg_val(r1, a_r, x_r, l_r, b_r, s_r, t_r));
          end
        end else if (sic) begin
          ta_nxt = {9'd0, b1[6:0], b2}; xadd_nxt = b1[7]; pc_nxt = pc_r + 24'd3;
        end else if (f4) begin
          ta_nxt = {4'd0, b1[3:0], b2, b3}; xadd_nxt = 1'b0; pc_nxt = pc_r + 24'd4;
        end else begin
          pc_nxt = pc_r + 24'd3; xadd_nxt = b1[7];
          unique case (b1[6:5])
            2'b10:   ta_nxt = {12'd0, disp} + b_r;
            2'b01:   ta_nxt = pc_r + 24'd3 + {{12{disp[11]}}, disp};
            default: ta_nxt = {12'd0, disp};
          endcase
        end
      end
      S_ADDR: begin
        ea_nxt = ta_sum;
        if (ind) begin
          raddr_nxt = ta_sum[MEM_AW-1:0]; cnt_nxt = 2'd3; ret_nxt = S_IND;
        end
      end
      S_IND: ea_nxt = buf_r;
      S_OPND: begin
        raddr_nxt = ea_r[MEM_AW-1:0];
        status_nxt = ST_EXEC;
        ret_nxt = S_EXE;
        priority case (1'b1)
          (opc == OPC_COMP) || (opc == OPC_LDA) || (opc == OPC_LDB) || (opc == OPC_LDT): begin
            if (imm) buf_nxt = ea_r;
            cnt_nxt = 2'd3;
          end
          opc == OPC_LDCH: begin
            if (imm) buf_nxt = ea_r;
            cnt_nxt = 2'd1;
          end
          opc == OPC_STA: begin wdat_nxt = a_r; cnt_nxt = 2'd3; end
          opc == OPC_STL: begin wdat_nxt = l_r; cnt_nxt = 2'd3; end
          opc == OPC_STX: begin wdat_nxt = x_r; cnt_nxt = 2'd3; end
          opc == OPC_STCH: begin wdat_nxt = {a_r[7:0], 16'd0}; cnt_nxt = 2'd1; end
          opc == OPC_J: pc_nxt = ea_r;
          opc == OPC_JEQ: if (cc_r == CC_EQ) pc_nxt = ea_r;
          opc == OPC_JLT: if (cc_r == CC_LT) pc_nxt = ea_r;
          opc == OPC_JSUB: begin l_nxt = pc_r; pc_nxt = ea_r; end
          default: pc_nxt = l_r;
        endcase
      end
      S_EXE: begin
        unique case (opc)
          OPC_COMP: cc_nxt = cmp3(a_r, buf_r);
          OPC_LDA:  a_nxt = buf_r;
          OPC_LDB:  b_nxt = buf_r;
          OPC_LDT:  t_nxt = buf_r;
          default:  a_nxt = {a_r[23:8], buf_r[7:0]};
        endcase
      end
      S_WR: begin
        ram_we = 1'b1;
        wdat_nxt = {wdat_r[15:0], 8'd0};
        raddr_nxt = raddr_r + MEM_AW'(1);
        cnt_nxt = cnt_r - 2'd1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; halted_r <= 1'b1; atbp_r <= 1'b0;
      pc_r <= '0; a_r <= '0; x_r <= '0; l_r <= '0; b_r <= '0; s_r <= '0; t_r <= '0;
      cc_r <= CC_EQ;
    end else begin
      state_r <= state_nxt; halted_r <= halted_nxt; atbp_r <= atbp_nxt;
      pc_r <= pc_nxt; a_r <= a_nxt; x_r <= x_nxt; l_r <= l_nxt; b_r <= b_nxt;
      s_r <= s_nxt; t_r <= t_nxt; cc_r <= cc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt; cnt_r <= cnt_nxt; raddr_r <= raddr_nxt; buf_r <= buf_nxt;
    ir0_r <= ir0_nxt; ta_r <= ta_nxt; ea_r <= ea_nxt; wdat_r <= wdat_nxt;
    xadd_r <= xadd_nxt; status_r <= status_nxt;
  end
endmodule
`default_nettype wire

/* design/sxs_checker.sv */
// Port-level checker for the step engine and its bind to the top level.
`default_nettype none
module sxs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic [1:0] out_cc
);
  import sxs_pkg::*;

  // drop any result beat during reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after accept");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_cc)))
    else $error("stalled result changed");

  // status and condition code stay in their code ranges
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status <= ST_END) && (out_cc != 2'd3)))
    else $error("bad status or condition code");
endmodule

bind sicxe_subset_instruction_step sxs_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_status (out_bus.status),
  .out_cc     (out_bus.cond_code)
);
`default_nettype wire
